// File: rtl/core/rbbe_pkg.sv
// rbbe_pkg: shared types and constants of the ring buffer byte engine
// request and result structs, command and status codes, shared unit result
// no dependencies
package rbbe_pkg;

  localparam int BUF_DEPTH_DEFAULT = 256;
  localparam int LEN_W = 9;

  localparam logic [LEN_W-1:0] RING_LEN_RESET = 9'd256;

  localparam logic [2:0] CMD_READ       = 3'd0;
  localparam logic [2:0] CMD_WRITE      = 3'd1;
  localparam logic [2:0] CMD_FILL_START = 3'd2;
  localparam logic [2:0] CMD_FILL_END   = 3'd3;
  localparam logic [2:0] CMD_FILL_RANGE = 3'd4;
  localparam logic [2:0] CMD_INC        = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_POS = 2'd1;
  localparam logic [1:0] ST_OFS = 2'd2;
  localparam logic [1:0] ST_CNT = 2'd3;

  localparam logic [LEN_W-1:0] MAX_WORD_BYTES = 9'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [8:0]  byte_count;
    logic [31:0] write_data;
    logic [7:0]  start_offset;
    logic [7:0]  end_offset;
    logic [7:0]  fill_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [7:0]  position;
  } out_res_t;

  typedef struct packed {
    logic             ge;
    logic [LEN_W-1:0] wrap;
    logic [LEN_W-1:0] step;
  } alu_res_t;

endpackage

// File: rtl/core/rbbe_ram.sv
// rbbe_ram: generic single-port ram with registered read
// parameters for width and depth; no dependencies
module rbbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/rbbe_wrap_alu.sv
// rbbe_wrap_alu: shared add with wrap at the ring length
// computes a + b, reduced once by len, and a step form that wraps to zero
// depends on rbbe_pkg
module rbbe_wrap_alu (
  input  logic [rbbe_pkg::LEN_W-1:0] a,
  input  logic [rbbe_pkg::LEN_W-1:0] b,
  input  logic [rbbe_pkg::LEN_W-1:0] len,
  output rbbe_pkg::alu_res_t         res
);
  import rbbe_pkg::*;

  logic [LEN_W:0] sum;
  logic [LEN_W:0] diff;
  logic           ge;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign ge   = sum >= {1'b0, len};
  assign diff = sum - {1'b0, len};

  assign res.ge   = ge;
  assign res.wrap = ge ? diff[LEN_W-1:0] : sum[LEN_W-1:0];
  assign res.step = ge ? '0 : sum[LEN_W-1:0];

endmodule

// File: rtl/core/ring_buffer_byte_engine.sv
// ring_buffer_byte_engine: byte ring buffer with a current position
// sequencer around one wrap adder and one single-port byte ram
// depends on rbbe_pkg, rbbe_wrap_alu, rbbe_ram
//
// usage: drive in_req and raise start; the request is taken at an edge where
// busy is low. each request gives exactly one result on out_res, shown for a
// single cycle with out_strobe; the receiver cannot stall it.
// cfg_we/cfg_wdata write ring_length (reset 256); the user must write it only
// while the block is idle, as no logic in the block enforces this.
// sequence: read, write and fill pass through a check state, one ram access
// per byte through the one ram port (up to 4 bytes for a word, up to len for
// a fill), and a closing state. a request that moves no bytes (errors, zero
// counts, increment, unused codes) ends with its check state.
// busy stays high from acceptance until the result shows; a new request can
// be taken in the cycle the result is shown.
// reset: position 0, ring_length 256, sequencer idle. buffer contents are
// undefined until written.
module ring_buffer_byte_engine #(
  parameter int BUF_DEPTH = rbbe_pkg::BUF_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  rbbe_pkg::in_req_t           in_req,
  output logic                        out_strobe,
  output rbbe_pkg::out_res_t          out_res,
  input  logic                        cfg_we,
  input  logic [rbbe_pkg::LEN_W-1:0]  cfg_wdata
);
  import rbbe_pkg::*;

  localparam int AW      = $clog2(BUF_DEPTH);
  localparam int LEN_CAP = (BUF_DEPTH < 511) ? BUF_DEPTH : 511;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_RUN} state_t;

  state_t           state_r, state_nxt;
  in_req_t          req_r, req_nxt;
  logic [LEN_W-1:0] ring_length_r;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] ptr_r, ptr_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [1:0]       rd_idx_r, rd_idx_nxt;
  logic [31:0]      rdata_r, rdata_nxt, rdata_m;
  logic             out_strobe_r, out_strobe_nxt;
  out_res_t         out_res_r, out_res_nxt;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] so9, eo9;
  logic [LEN_W-1:0] alu_a, alu_b;
  alu_res_t         alu_res;
  logic             ram_en, ram_we;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             go;
  logic [1:0]       st;
  logic [LEN_W-1:0] first, count;
  logic             is_rw, is_read;

  assign len = (ring_length_r > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : ring_length_r;
  assign so9 = {1'b0, req_r.start_offset};
  assign eo9 = {1'b0, req_r.end_offset};
  assign is_read = req_r.command == CMD_READ;
  assign is_rw   = is_read || (req_r.command == CMD_WRITE);

  always_comb begin
    alu_a = pos_r;
    alu_b = LEN_W'(1);
    if (state_r == S_RUN) begin
      alu_a = ptr_r;
    end else if (req_r.command == CMD_FILL_END) begin
      alu_a = eo9;
      alu_b = len - req_r.byte_count;
    end else if (req_r.command == CMD_FILL_RANGE) begin
      alu_a = eo9;
      alu_b = len - so9;
    end
  end

  rbbe_wrap_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .len (len),
    .res (alu_res)
  );

  assign ram_wdata = (req_r.command == CMD_WRITE) ?
                     req_r.write_data[{idx_r, 3'b000} +: 8] : req_r.fill_value;

  rbbe_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (AW'(ptr_r)),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // merge the byte returned by the previous read
  always_comb begin
    rdata_m = rdata_r;
    if (rd_pend_r) begin
      rdata_m[{rd_idx_r, 3'b000} +: 8] = ram_rdata;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    pos_nxt        = pos_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    rdata_nxt      = rdata_m;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    go             = 1'b0;
    st             = ST_OK;
    first          = '0;
    count          = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          rdata_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (req_r.command)
          CMD_READ, CMD_WRITE: begin
            if (pos_r >= len) begin
              st = ST_POS;
            end else if (req_r.byte_count == '0) begin
              st = ST_OK;
            end else if (req_r.byte_count > MAX_WORD_BYTES || req_r.byte_count > len) begin
              st = ST_CNT;
            end else begin
              go    = 1'b1;
              first = pos_r;
              count = req_r.byte_count;
            end
          end
          CMD_FILL_START: begin
            if (so9 >= len) begin
              st = ST_OFS;
            end else if (req_r.byte_count > len) begin
              st = ST_CNT;
            end else if (req_r.byte_count != '0) begin
              go    = 1'b1;
              first = so9;
              count = req_r.byte_count;
            end
          end
          CMD_FILL_END: begin
            if (eo9 >= len) begin
              st = ST_OFS;
            end else if (req_r.byte_count > len) begin
              st = ST_CNT;
            end else if (req_r.byte_count != '0) begin
              go    = 1'b1;
              first = alu_res.wrap;
              count = req_r.byte_count;
            end
          end
          CMD_FILL_RANGE: begin
            if (so9 >= len || eo9 >= len) begin
              st = ST_OFS;
            end else if (so9 == eo9) begin
              go    = 1'b1;
              first = '0;
              count = len;
            end else begin
              go    = 1'b1;
              first = so9;
              count = alu_res.wrap;
            end
          end
          CMD_INC: begin
            pos_nxt = alu_res.step;
          end
          default: begin
          end
        endcase
        if (go) begin
          state_nxt = S_RUN;
          ptr_nxt   = first;
          cnt_nxt   = count;
          idx_nxt   = '0;
        end else begin
          state_nxt             = S_IDLE;
          out_strobe_nxt        = 1'b1;
          out_res_nxt.status    = st;
          out_res_nxt.read_data = '0;
          out_res_nxt.position  = pos_nxt[7:0];
        end
      end
      S_RUN: begin
        if (cnt_r != '0) begin
          ram_en      = 1'b1;
          ram_we      = !is_read;
          ptr_nxt     = alu_res.step;
          cnt_nxt     = cnt_r - LEN_W'(1);
          idx_nxt     = idx_r + 2'd1;
          rd_pend_nxt = is_read;
          rd_idx_nxt  = idx_r;
        end else begin
          if (is_rw) begin
            pos_nxt = ptr_r;
          end
          state_nxt             = S_IDLE;
          out_strobe_nxt        = 1'b1;
          out_res_nxt.status    = ST_OK;
          out_res_nxt.read_data = is_read ? rdata_m : '0;
          out_res_nxt.position  = pos_nxt[7:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pos_r         <= '0;
      ring_length_r <= RING_LEN_RESET;
      rd_pend_r     <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        ring_length_r <= cfg_wdata;
      end
    end
    req_r     <= req_nxt;
    ptr_r     <= ptr_nxt;
    cnt_r     <= cnt_nxt;
    idx_r     <= idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rdata_r   <= rdata_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but engine not busy");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("engine went idle without a result");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back to back result strobes");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.status != ST_OK |-> out_res.read_data == '0)
    else $error("read data on a failed request");

endmodule

// File: tb/ring_buffer_byte_engine_checker.sv
`timescale 1ns / 1ps
// ring_buffer_byte_engine_checker: watches the request, result and config ports of the
// ring buffer engine, tracks its own memory, position and length, checks every result
// depends on rbbe_pkg
module ring_buffer_byte_engine_checker
  import rbbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_req_t          in_req,
  input  logic             out_strobe,
  input  out_res_t         out_res,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  output int               mismatch_count,
  output int               results_checked,
  output int               pending_count
);

  localparam int DEPTH = BUF_DEPTH_DEFAULT;

  logic [7:0]  ring_mem [DEPTH];
  int unsigned cur_pos;
  int unsigned ring_len;
  out_res_t    awaited_results [$];

  function automatic void fill_ring(int unsigned first, int unsigned count,
                                    int unsigned len, logic [7:0] value);
    int unsigned i;
    for (i = 0; i < count; i++) ring_mem[(first + i) % len] = value;
  endfunction

  function automatic out_res_t next_ring_result(in_req_t r);
    out_res_t    res;
    int unsigned len;
    int unsigned cnt;
    int unsigned first;
    int unsigned i;
    len = (ring_len > DEPTH) ? DEPTH : ring_len;
    cnt = 32'(r.byte_count);
    res.status = ST_OK;
    res.read_data = '0;
    case (r.command)
      CMD_READ, CMD_WRITE: begin
        if (cur_pos >= len) begin
          res.status = ST_POS;
        end else if (cnt == 0) begin
          res.status = ST_OK;
        end else if (cnt > MAX_WORD_BYTES || cnt > len) begin
          res.status = ST_CNT;
        end else begin
          for (i = 0; i < cnt; i++) begin
            if (r.command == CMD_READ) res.read_data[8*i +: 8] = ring_mem[(cur_pos + i) % len];
            else ring_mem[(cur_pos + i) % len] = r.write_data[8*i +: 8];
          end
          cur_pos = (cur_pos + cnt) % len;
        end
      end
      CMD_FILL_START, CMD_FILL_END: begin
        first = (r.command == CMD_FILL_START) ? 32'(r.start_offset) : 32'(r.end_offset);
        if (first >= len) begin
          res.status = ST_OFS;
        end else if (cnt > len) begin
          res.status = ST_CNT;
        end else if (cnt != 0) begin
          if (r.command == CMD_FILL_END) first = (r.end_offset + len - cnt) % len;
          fill_ring(first, cnt, len, r.fill_value);
        end
      end
      CMD_FILL_RANGE: begin
        if (r.start_offset >= len || r.end_offset >= len) begin
          res.status = ST_OFS;
        end else if (r.start_offset == r.end_offset) begin
          fill_ring(0, len, len, r.fill_value);
        end else begin
          fill_ring(32'(r.start_offset), (r.end_offset + len - r.start_offset) % len, len,
                    r.fill_value);
        end
      end
      CMD_INC: begin
        cur_pos = cur_pos + 1;
        if (cur_pos >= len) cur_pos = 0;
      end
      default: ;
    endcase
    res.position = cur_pos[7:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      cur_pos = 0;
      ring_len = 32'(RING_LEN_RESET);
      awaited_results.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: status %0d data %h position %0d",
                 out_res.status, out_res.read_data, out_res.position);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (out_res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_res.status);
            mismatch_count++;
          end
          if (out_res.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_res.read_data);
            mismatch_count++;
          end
          if (out_res.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_res.position);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) ring_len = 32'(cfg_wdata);
      if (start && !busy) awaited_results.push_back(next_ring_result(in_req));
    end
    pending_count <= awaited_results.size();
  end

endmodule

// File: tb/ring_buffer_byte_engine_test.sv
`timescale 1ns / 1ps
// ring_buffer_byte_engine_test: top of the ring buffer engine testbench, drives directed
// and random requests over a series of ring lengths and gives the verdict
// depends on rbbe_pkg, ring_buffer_byte_engine, ring_buffer_byte_engine_checker
module ring_buffer_byte_engine_test;
  import rbbe_pkg::*;

  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam int NUM_PHASES = 13;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_req_t          in_req = '0;
  logic             out_strobe;
  out_res_t         out_res;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int results_checked;
  int pending_count;
  int requests_sent;
  int length_settings;
  int unsigned ring_len_now = 256;
  bit idle_allowed = 1'b1;
  int unsigned phase_lengths [NUM_PHASES] = '{256, 1, 2, 3, 17, 100, 511, 64, 0, 300, 8, 4, 256};

  ring_buffer_byte_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  ring_buffer_byte_engine_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req          (in_req),
    .out_strobe      (out_strobe),
    .out_res         (out_res),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_checked (results_checked),
    .pending_count   (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic in_req_t make_req(logic [2:0] cmd, logic [8:0] cnt, logic [31:0] wdata,
                                       logic [7:0] so, logic [7:0] eo, logic [7:0] fv);
    in_req_t r;
    r.command = cmd;
    r.byte_count = cnt;
    r.write_data = wdata;
    r.start_offset = so;
    r.end_offset = eo;
    r.fill_value = fv;
    return r;
  endfunction

  function automatic logic [8:0] fill_count(int unsigned len);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 9'($urandom_range(0, (len < 8) ? len : 8));
    else if (pick < 9) return 9'(len);
    else return 9'($urandom_range(0, 511));
  endfunction

  function automatic in_req_t random_request(int unsigned len);
    in_req_t     r;
    int unsigned pick;
    int unsigned top_ofs;
    top_ofs = (len > 0) ? len - 1 : 0;
    r = make_req(CMD_INC, 9'($urandom_range(0, 511)), $urandom, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      r.command = pick[0] ? CMD_WRITE : CMD_READ;
      if ($urandom_range(0, 9) != 0) r.byte_count = 9'($urandom_range(0, 4));
    end else if (pick < 50) begin
      r.command = CMD_FILL_START;
      if ($urandom_range(0, 9) != 0) r.start_offset = 8'($urandom_range(0, top_ofs));
      r.byte_count = fill_count(len);
    end else if (pick < 62) begin
      r.command = CMD_FILL_END;
      if ($urandom_range(0, 9) != 0) r.end_offset = 8'($urandom_range(0, top_ofs));
      r.byte_count = fill_count(len);
    end else if (pick < 74) begin
      r.command = CMD_FILL_RANGE;
      if ($urandom_range(0, 9) != 0) begin
        r.start_offset = 8'($urandom_range(0, top_ofs));
        r.end_offset = 8'($urandom_range(0, top_ofs));
      end
      if ($urandom_range(0, 5) == 0) r.end_offset = r.start_offset;
    end else if (pick >= 97) begin
      r.command = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    end
    return r;
  endfunction

  task automatic send_request(in_req_t r);
    in_req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    requests_sent++;
    if (idle_allowed && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic write_ring_length(logic [8:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_len_now = (value > 256) ? 256 : value;
    length_settings++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // whole ring first, so every later read hits written bytes
    send_request(make_req(CMD_FILL_RANGE, 9'd0, 32'd0, 8'd0, 8'd0, 8'hA5));
    send_request(make_req(CMD_WRITE, 9'd4, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_READ, 9'd4, 32'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_WRITE, 9'd0, 32'h1234_5678, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_READ, 9'd5, 32'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_WRITE, 9'd511, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_FILL_START, 9'd256, 32'd0, 8'd255, 8'd0, 8'h00));
    send_request(make_req(CMD_FILL_START, 9'd257, 32'd0, 8'd0, 8'd0, 8'hFF));
    send_request(make_req(CMD_FILL_END, 9'd3, 32'd0, 8'd0, 8'd0, 8'h5A));
    send_request(make_req(CMD_FILL_END, 9'd0, 32'd0, 8'd0, 8'd255, 8'h11));
    send_request(make_req(CMD_FILL_RANGE, 9'd0, 32'd0, 8'd250, 8'd5, 8'hFF));
    send_request(make_req(CMD_FILL_RANGE, 9'd0, 32'd0, 8'd10, 8'd3, 8'h3C));
    send_request(make_req(CMD_INC, 9'd0, 32'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_UNUSED_6, 9'd511, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(CMD_UNUSED_7, 9'd0, 32'd0, 8'd0, 8'd0, 8'd0));

    // position now lies past the shortened ring
    write_ring_length(9'd5);
    send_request(make_req(CMD_READ, 9'd1, 32'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_WRITE, 9'd2, 32'hDEAD_BEEF, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_INC, 9'd0, 32'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_WRITE, 9'd4, 32'h1234_5678, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_READ, 9'd3, 32'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_FILL_START, 9'd1, 32'd0, 8'd5, 8'd0, 8'h77));
    send_request(make_req(CMD_FILL_RANGE, 9'd0, 32'd0, 8'd1, 8'd5, 8'h77));
    send_request(make_req(CMD_FILL_END, 9'd6, 32'd0, 8'd0, 8'd2, 8'h77));

    write_ring_length(9'd0);
    send_request(make_req(CMD_READ, 9'd1, 32'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(CMD_FILL_START, 9'd0, 32'd0, 8'd0, 8'd0, 8'h00));
    send_request(make_req(CMD_INC, 9'd0, 32'd0, 8'd0, 8'd0, 8'd0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_ring_length(9'(phase_lengths[ph]));
      idle_allowed = !(ph >= 4 && ph <= 6);
      repeat ((ring_len_now == 0) ? 30 : 140) send_request(random_request(ring_len_now));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests over %0d ring length settings, %0d results checked",
             requests_sent, length_settings, results_checked);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rbbe_pkg.sv
rtl/core/rbbe_ram.sv
rtl/core/rbbe_wrap_alu.sv
rtl/core/ring_buffer_byte_engine.sv
tb/ring_buffer_byte_engine_checker.sv
tb/ring_buffer_byte_engine_test.sv
